>>> rtl/tpag_pkg.sv
// Package for the tensor permute address generator.
// Holds register indexes, field widths and the control bundle shared by the setup unit
// and the top level. Depends on nothing.
package tpag_pkg;

    localparam int RANK_W        = 3;
    localparam int FIELD_W       = 3;
    localparam int ORDER_W       = 15;
    localparam int SIZE_W        = 16;
    localparam int ESZ_W         = 2;
    localparam int NUM_SIZE_REGS = 5;
    localparam int MIN_RANK      = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    // Element count limit is 2^32, held exactly in a 33-bit running product.
    localparam int              CNT_W     = 33;
    localparam logic [CNT_W-1:0] COUNT_MAX = {1'b1, 32'h0000_0000};

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_RANK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM  = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [RANK_W-1:0]  RANK_RESET  = 3'd2;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 15'd8;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 16'd1;
    localparam logic [ESZ_W-1:0]   ELEM_RESET  = 2'd0;

    typedef struct packed {
        logic              busy;
        logic              cfg_ok;
        logic [RANK_W-1:0] rank;
        logic [ESZ_W-1:0]  elem_log2;
        logic              load_src;
        logic              load_dst;
        logic [RANK_W-1:0] load_idx;
    } tpag_ctrl_t;

endpackage

>>> rtl/tensor_permute_address_generator_unit.sv
// Top level of the tensor permute address generator.
// Holds the destination counters and offset terms and the two pipeline registers.
// Depends on tpag_pkg and tpag_setup.
//
// Usage: each beat on the s_ channel asks for one address pair; s_restart set returns the
// walk to the first destination position before it is emitted. Each beat on the m_
// channel carries the source and destination byte offsets of one position in
// destination row-major order, a last flag on the final position, and size_error when the
// configuration is invalid (offsets and last are then zero and the walk holds).
// m_valid rises when the input register hands the beat on; one beat is accepted per cycle
// unless a setup pass, a write or a stall holds s_ready low. A beat is registered at the
// input and its result in the output register, so a stalled receiver holds m_valid with
// the payload steady while one more beat may enter; ready then drops until the output drains.
// Each offset is the sum of per-dimension terms that step by precomputed stride increments,
// so no multiply sits on the beat path.
// Configuration writes land on the cfg_ port. After reset and after every write, a setup
// pass (source strides, destination strides, source terms, destination terms) rebuilds
// strides, counter limits and offset terms; s_ready is low during that pass and in the cycle of the write.
module tensor_permute_address_generator_unit
    import tpag_pkg::*;
#(
    parameter int MAX_RANK    = 5,
    parameter int DIM_BITS    = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_restart,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [OFFSET_BITS+2:0]   m_source_byte_offset,
    output logic [OFFSET_BITS+2:0]   m_dest_byte_offset,
    output logic                     m_last_element,
    output logic                     m_size_error
);

    localparam int DIMS  = (MAX_RANK < NUM_SIZE_REGS) ? MAX_RANK : NUM_SIZE_REGS;
    localparam int IDX_W = $clog2(DIMS);
    localparam int OUT_W = OFFSET_BITS + 3;

    tpag_ctrl_t             ctrl;
    logic [OFFSET_BITS-1:0] sinc [DIMS];
    logic [OFFSET_BITS-1:0] dinc [DIMS];
    logic [DIM_BITS-1:0]    lim [DIMS];
    logic [OFFSET_BITS-1:0] term_val;

    logic                   in_valid_reg;
    logic                   in_restart_reg;
    logic [DIM_BITS-1:0]    cnt_reg [DIMS];
    logic [OFFSET_BITS-1:0] tsrc_reg [DIMS];
    logic [OFFSET_BITS-1:0] tdst_reg [DIMS];
    logic                   m_valid_reg;
    logic [OUT_W-1:0]       m_src_reg;
    logic [OUT_W-1:0]       m_dst_reg;
    logic                   m_last_reg;
    logic                   m_err_reg;

    logic [DIM_BITS-1:0]    cnt_cur [DIMS];
    logic [OFFSET_BITS-1:0] tsrc_cur [DIMS];
    logic [OFFSET_BITS-1:0] tdst_cur [DIMS];
    logic [DIM_BITS-1:0]    cnt_next [DIMS];
    logic [OFFSET_BITS-1:0] tsrc_next [DIMS];
    logic [OFFSET_BITS-1:0] tdst_next [DIMS];
    logic [OUT_W-1:0]       src_next;
    logic [OUT_W-1:0]       dst_next;
    logic                   last_next;
    logic                   out_free;
    logic                   step;

    tpag_setup #(
        .DIMS        (DIMS),
        .MAX_RANK    (MAX_RANK),
        .DIM_BITS    (DIM_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cnt       (cnt_reg),
        .sinc      (sinc),
        .dinc      (dinc),
        .lim       (lim),
        .term_val  (term_val),
        .ctrl      (ctrl)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !ctrl.busy && !cfg_we && (!in_valid_reg || out_free);

    always_comb begin
        logic [OFFSET_BITS-1:0] sum_src;
        logic [OFFSET_BITS-1:0] sum_dst;
        logic                   wrap [DIMS];
        logic                   carry;
        logic                   last;
        sum_src = '0;
        sum_dst = '0;
        last    = 1'b1;
        carry   = 1'b1;
        for (int k = 0; k < DIMS; k++) begin
            cnt_cur[k]  = in_restart_reg ? '0 : cnt_reg[k];
            tsrc_cur[k] = in_restart_reg ? '0 : tsrc_reg[k];
            tdst_cur[k] = in_restart_reg ? '0 : tdst_reg[k];
            sum_src     = sum_src + tsrc_cur[k];
            sum_dst     = sum_dst + tdst_cur[k];
            // A counter left beyond its limit by a size change also wraps.
            wrap[k]     = cnt_cur[k] >= lim[k];
            if ((RANK_W'(k) < ctrl.rank) && !wrap[k]) begin
                last = 1'b0;
            end
            cnt_next[k]  = cnt_cur[k];
            tsrc_next[k] = tsrc_cur[k];
            tdst_next[k] = tdst_cur[k];
        end

        if (ctrl.cfg_ok) begin
            // Innermost dimension first; the carry stops at the first one that counts up.
            for (int k = DIMS - 1; k >= 0; k--) begin
                if ((RANK_W'(k) < ctrl.rank) && carry) begin
                    if (wrap[k]) begin
                        cnt_next[k]  = '0;
                        tsrc_next[k] = '0;
                        tdst_next[k] = '0;
                    end else begin
                        cnt_next[k]  = cnt_cur[k] + DIM_BITS'(1);
                        tsrc_next[k] = tsrc_cur[k] + sinc[k];
                        tdst_next[k] = tdst_cur[k] + dinc[k];
                    end
                    carry = wrap[k];
                end
            end
            src_next  = OUT_W'(sum_src) << ctrl.elem_log2;
            dst_next  = OUT_W'(sum_dst) << ctrl.elem_log2;
            last_next = last;
        end else begin
            src_next  = '0;
            dst_next  = '0;
            last_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int k = 0; k < DIMS; k++) begin
                cnt_reg[k]  <= '0;
                tsrc_reg[k] <= '0;
                tdst_reg[k] <= '0;
            end
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg   <= 1'b1;
                in_restart_reg <= s_restart;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end

            if (step) begin
                m_valid_reg <= 1'b1;
                m_src_reg   <= src_next;
                m_dst_reg   <= dst_next;
                m_last_reg  <= last_next;
                m_err_reg   <= !ctrl.cfg_ok;
                cnt_reg     <= cnt_next;
                tsrc_reg    <= tsrc_next;
                tdst_reg    <= tdst_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Setup pass reloads the offset terms for the counters as they stand.
            if (ctrl.load_src) begin
                tsrc_reg[ctrl.load_idx[IDX_W-1:0]] <= term_val;
            end
            if (ctrl.load_dst) begin
                tdst_reg[ctrl.load_idx[IDX_W-1:0]] <= term_val;
            end
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_source_byte_offset = m_src_reg;
    assign m_dest_byte_offset   = m_dst_reg;
    assign m_last_element       = m_last_reg;
    assign m_size_error         = m_err_reg;

endmodule

>>> rtl/tpag_setup.sv
// Configuration registers and setup sequencer of the tensor permute address generator.
// After any write it derives strides, counter limits and per-dimension offset terms with
// one shared multiplier, one dimension per cycle. Uses tpag_pkg.
module tpag_setup
    import tpag_pkg::*;
#(
    parameter int DIMS        = 5,
    parameter int MAX_RANK    = 5,
    parameter int DIM_BITS    = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [DIM_BITS-1:0]    cnt [DIMS],
    output logic [OFFSET_BITS-1:0] sinc [DIMS],
    output logic [OFFSET_BITS-1:0] dinc [DIMS],
    output logic [DIM_BITS-1:0]    lim [DIMS],
    output logic [OFFSET_BITS-1:0] term_val,
    output tpag_ctrl_t             ctrl
);

    localparam int IDX_W = $clog2(DIMS);
    localparam int SZ_W  = (DIM_BITS < SIZE_W) ? DIM_BITS : SIZE_W;
    localparam int AW    = (OFFSET_BITS > CNT_W) ? OFFSET_BITS : CNT_W;
    localparam int BW    = DIM_BITS;
    localparam int PW    = AW + BW;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SSTR  = 3'd1;
    localparam logic [2:0] ST_DSTR  = 3'd2;
    localparam logic [2:0] ST_STERM = 3'd3;
    localparam logic [2:0] ST_DTERM = 3'd4;

    logic [RANK_W-1:0]      rank_reg;
    logic [ORDER_W-1:0]     order_reg;
    logic [SIZE_W-1:0]      size_reg [DIMS];
    logic [ESZ_W-1:0]       elem_reg;

    logic [2:0]             state_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [AW-1:0]          acc_reg;
    logic                   ovf_reg;
    logic                   cfg_ok_reg;
    logic [OFFSET_BITS-1:0] sstr_reg [DIMS];
    logic [OFFSET_BITS-1:0] sinc_reg [DIMS];
    logic [OFFSET_BITS-1:0] dinc_reg [DIMS];
    logic [DIM_BITS-1:0]    lim_reg [DIMS];

    logic [SZ_W-1:0]        size_eff [DIMS];
    logic [FIELD_W-1:0]     ord [DIMS];
    logic                   ord_ok [DIMS];
    logic [IDX_W-1:0]       ord_idx [DIMS];
    logic [SZ_W-1:0]        dsz [DIMS];
    logic                   struct_ok;
    logic                   in_rank;
    logic [AW-1:0]          mul_a;
    logic [BW-1:0]          mul_b;
    logic [PW-1:0]          mul_p;
    logic                   mul_ovf;

    // Decode of the order fields and the permuted destination sizes.
    always_comb begin
        for (int k = 0; k < DIMS; k++) begin
            size_eff[k] = size_reg[k][SZ_W-1:0];
            ord[k]      = order_reg[FIELD_W*k +: FIELD_W];
            ord_ok[k]   = int'(ord[k]) < DIMS;
            ord_idx[k]  = ord[k][IDX_W-1:0];
            dsz[k]      = ord_ok[k] ? size_eff[ord_idx[k]] : '0;
        end
    end

    // Rank range, permutation and nonzero size checks.
    always_comb begin
        logic [2**FIELD_W-1:0] seen;
        logic                  ok;
        seen = '0;
        ok   = (int'(rank_reg) >= MIN_RANK) && (int'(rank_reg) <= MAX_RANK)
            && (int'(rank_reg) <= NUM_SIZE_REGS);
        for (int k = 0; k < DIMS; k++) begin
            if (RANK_W'(k) < rank_reg) begin
                if ((ord[k] >= FIELD_W'(rank_reg)) || seen[ord[k]]) begin
                    ok = 1'b0;
                end
                seen[ord[k]] = 1'b1;
                if (size_eff[k] == '0) begin
                    ok = 1'b0;
                end
            end
        end
        struct_ok = ok;
    end

    assign in_rank = RANK_W'(idx_reg) < rank_reg;

    always_comb begin
        case (state_reg)
            ST_SSTR: begin
                mul_a = acc_reg;
                mul_b = BW'(size_eff[idx_reg]);
            end
            ST_DSTR: begin
                mul_a = acc_reg;
                mul_b = BW'(dsz[idx_reg]);
            end
            ST_STERM: begin
                mul_a = AW'(sstr_reg[ord_idx[idx_reg]]);
                mul_b = cnt[idx_reg];
            end
            ST_DTERM: begin
                mul_a = AW'(dinc_reg[idx_reg]);
                mul_b = cnt[idx_reg];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = PW'(mul_a) * PW'(mul_b);
    assign mul_ovf  = (|mul_p[PW-1:CNT_W]) || (mul_p[CNT_W-1:0] > COUNT_MAX);
    assign term_val = in_rank ? mul_p[OFFSET_BITS-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg   <= RANK_RESET;
            order_reg  <= ORDER_RESET;
            elem_reg   <= ELEM_RESET;
            for (int i = 0; i < DIMS; i++) begin
                size_reg[i] <= SIZE_RESET;
            end
            state_reg  <= ST_SSTR;
            idx_reg    <= IDX_W'(DIMS - 1);
            acc_reg    <= AW'(1);
            ovf_reg    <= 1'b0;
            cfg_ok_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_RANK:  rank_reg  <= cfg_wdata[RANK_W-1:0];
                    REG_ORDER: order_reg <= cfg_wdata[ORDER_W-1:0];
                    REG_ELEM:  elem_reg  <= cfg_wdata[ESZ_W-1:0];
                    default: begin
                        // Sizes beyond the supported rank are never used.
                        for (int i = 0; i < DIMS; i++) begin
                            if (cfg_index == CFG_IDX_W'(int'(REG_SIZE0) + i)) begin
                                size_reg[i] <= cfg_wdata[SIZE_W-1:0];
                            end
                        end
                    end
                endcase
                state_reg <= ST_SSTR;
                idx_reg   <= IDX_W'(DIMS - 1);
                acc_reg   <= AW'(1);
                ovf_reg   <= 1'b0;
            end else begin
                case (state_reg)
                    ST_SSTR: begin
                        // Row-major source strides, innermost first, with the exact
                        // element count kept alongside for the size check.
                        if (in_rank) begin
                            sstr_reg[idx_reg] <= OFFSET_BITS'(acc_reg);
                            if (mul_ovf) begin
                                ovf_reg <= 1'b1;
                            end
                        end
                        if (idx_reg == '0) begin
                            state_reg <= ST_DSTR;
                            idx_reg   <= IDX_W'(DIMS - 1);
                            acc_reg   <= AW'(1);
                        end else begin
                            idx_reg <= idx_reg - IDX_W'(1);
                            if (in_rank) begin
                                acc_reg <= AW'(mul_p[CNT_W-1:0]);
                            end
                        end
                    end
                    ST_DSTR: begin
                        if (in_rank) begin
                            dinc_reg[idx_reg] <= OFFSET_BITS'(acc_reg);
                            lim_reg[idx_reg]  <= DIM_BITS'(dsz[idx_reg]) - DIM_BITS'(1);
                            acc_reg <= AW'(mul_p[OFFSET_BITS-1:0]);
                        end
                        if (idx_reg == '0) begin
                            state_reg <= ST_STERM;
                            idx_reg   <= IDX_W'(DIMS - 1);
                        end else begin
                            idx_reg <= idx_reg - IDX_W'(1);
                        end
                    end
                    ST_STERM: begin
                        sinc_reg[idx_reg] <= sstr_reg[ord_idx[idx_reg]];
                        if (idx_reg == '0) begin
                            state_reg <= ST_DTERM;
                            idx_reg   <= IDX_W'(DIMS - 1);
                        end else begin
                            idx_reg <= idx_reg - IDX_W'(1);
                        end
                    end
                    ST_DTERM: begin
                        if (idx_reg == '0) begin
                            state_reg  <= ST_IDLE;
                            cfg_ok_reg <= struct_ok && !ovf_reg;
                        end else begin
                            idx_reg <= idx_reg - IDX_W'(1);
                        end
                    end
                    default: begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign sinc = sinc_reg;
    assign dinc = dinc_reg;
    assign lim  = lim_reg;

    always_comb begin
        ctrl           = '0;
        ctrl.busy      = state_reg != ST_IDLE;
        ctrl.cfg_ok    = cfg_ok_reg;
        ctrl.rank      = rank_reg;
        ctrl.elem_log2 = elem_reg;
        ctrl.load_src  = state_reg == ST_STERM;
        ctrl.load_dst  = state_reg == ST_DTERM;
        ctrl.load_idx  = RANK_W'(idx_reg);
    end

endmodule
